/* rtl/pbrms_pkg.sv */
// ----------------------------------------------------------------------------
// pbrms_pkg: shared constants for the per-bin running mean / stddev block
// Field widths of the request and result, and the default sizing.
// ----------------------------------------------------------------------------
package pbrms_pkg;

  // Field widths.
  localparam int unsigned BIN_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SUMSQ_W = 64;

  // Default sizing.
  localparam int unsigned NUM_BINS_DEF    = 32;
  localparam int unsigned MAX_SAMPLES_DEF = 1024;

  // Iteration counts of the shared shift-subtract unit.
  localparam int unsigned MEAN_DIV_STEPS = DATA_W;
  localparam int unsigned SUMSQ_DIV_STEPS = SUMSQ_W;
  localparam int unsigned SQRT_STEPS = SUMSQ_W / 2;
  localparam int unsigned ITER_W = $clog2(SUMSQ_DIV_STEPS + 1);

endpackage

/* rtl/per_bin_running_mean_stddev.sv */
// ----------------------------------------------------------------------------
// per_bin_running_mean_stddev: Welford running mean and stddev per bin
// One request carries a bin, a Q24.8 sample and first/last marks. The bin's
// statistics live in one synchronous memory; a last request reports the bin,
// its mean and floor(sqrt(sumsq / count)).
// ----------------------------------------------------------------------------
// Each bin keeps a mean (Q24.8), a sum of squared deviations (Q48.16) and a
// sample count in one memory entry. A request with first set restarts its bin;
// a first+last request reports the sample with a stddev of zero. Any other
// request reads the entry, divides the signed deviation by the new count with
// truncation toward zero, updates mean and sum of squares, and writes the
// entry back after the 32 steps of the bit-serial divider. A last request
// adds a 64-step division of the sum by the count and a 32-step integer
// square root on the same shift-subtract datapath. The count saturates at
// MAX_SAMPLES and the sum of squares at all ones. Requests for a bin at or
// above NUM_BINS are taken and dropped. Only one request is in flight; the
// next is taken while a finished result still waits on out_stall_i. A
// non-first request to a bin that no first request has started reads an
// unwritten entry and returns garbage.
// ----------------------------------------------------------------------------
module per_bin_running_mean_stddev
  import pbrms_pkg::*;
#(
  parameter int unsigned NUM_BINS    = NUM_BINS_DEF,
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [BIN_W-1:0]   bin_i,
  input  logic [DATA_W-1:0]  sample_i,
  input  logic               first_i,
  input  logic               last_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BIN_W-1:0]   bin_out_o,
  output logic [DATA_W-1:0]  mean_o,
  output logic [DATA_W-1:0]  stddev_o
);

  localparam int unsigned ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ROOT_W = SUMSQ_W / 2;
  localparam int unsigned SQREM_W = ROOT_W + 1;

  typedef struct packed {
    logic [DATA_W-1:0]  mean;
    logic [SUMSQ_W-1:0] sumsq;
    logic [CNT_W-1:0]   count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVM,
    ST_MUL,
    ST_ACC,
    ST_DIVS,
    ST_SQRT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Statistics memory, one entry per bin, registered read port.
  entry_t stat_mem [NUM_BINS];
  entry_t rd_q;
  entry_t wr_entry;
  logic   mem_we;
  logic   rd_en;

  // Request registers.
  logic [BIN_W-1:0]  bin_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] sample_q;
  logic              first_q;
  logic              last_q;

  // Working registers.
  logic [DATA_W-1:0]  mean_q;
  logic [SUMSQ_W-1:0] sumsq_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;
  logic [DATA_W-1:0]  dmag_q;
  logic [SUMSQ_W-1:0] prod_q;
  logic [SUMSQ_W-1:0] div_q;
  logic [CNT_W-1:0]   div_rem_q;
  logic [ITER_W-1:0]  iter_q;
  logic [ROOT_W-1:0]  root_q;
  logic [SQREM_W-1:0] sq_rem_q;

  // Result registers.
  logic              out_valid_q;
  logic [BIN_W-1:0]  out_bin_q;
  logic [DATA_W-1:0] out_mean_q;
  logic [DATA_W-1:0] out_stddev_q;

  logic in_accept;
  logic in_range;
  logic out_free;

  // Datapath terms.
  logic [CNT_W-1:0]   n_new;
  logic [CNT_W:0]     div_shift;
  logic               div_ge;
  logic [CNT_W:0]     div_diff;
  logic [SQREM_W+1:0] sq_shift;
  logic [SQREM_W+1:0] sq_trial;
  logic               sq_ge;
  logic [SQREM_W+1:0] sq_diff;
  logic [DATA_W-1:0]  qmag;
  logic [DATA_W-1:0]  mean_new;
  logic [DATA_W-1:0]  dev_new;
  logic [SUMSQ_W:0]   sum_wide;
  logic [SUMSQ_W-1:0] sum_sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(bin_i) < NUM_BINS);
  assign rd_en      = in_accept && in_range;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign bin_out_o   = out_bin_q;
  assign mean_o      = out_mean_q;
  assign stddev_o    = out_stddev_q;

  always_comb begin
    // New count: advance and saturate at MAX_SAMPLES; never divide by zero.
    n_new = (rd_q.count < CNT_W'(MAX_SAMPLES)) ? rd_q.count + CNT_W'(1) : rd_q.count;
    if (n_new == '0) begin
      n_new = CNT_W'(1);
    end

    // One restoring division step.
    div_shift = {div_rem_q, div_q[SUMSQ_W-1]};
    div_ge    = (div_shift >= {1'b0, cnt_q});
    div_diff  = div_shift - {1'b0, cnt_q};

    // One square-root digit step.
    sq_shift = {sq_rem_q, div_q[SUMSQ_W-1 -: 2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_ge    = (sq_shift >= sq_trial);
    sq_diff  = sq_shift - sq_trial;

    // Mean update; the second factor shrinks the deviation by the quotient.
    qmag     = div_q[DATA_W-1:0];
    mean_new = neg_q ? mean_q - qmag : mean_q + qmag;
    dev_new  = dmag_q - qmag;

    // Saturating accumulate of the product.
    sum_wide = {1'b0, sumsq_q} + {1'b0, prod_q};
    sum_sat  = sum_wide[SUMSQ_W] ? '1 : sum_wide[SUMSQ_W-1:0];

    // Write-back data.
    mem_we   = 1'b0;
    wr_entry = '{mean: mean_new, sumsq: sum_sat, count: cnt_q};
    if (state_q == ST_READ && first_q) begin
      mem_we   = 1'b1;
      wr_entry = '{mean: sample_q, sumsq: '0, count: CNT_W'(1)};
    end else if (state_q == ST_ACC) begin
      mem_we   = 1'b1;
      wr_entry = '{mean: mean_q, sumsq: sum_sat, count: cnt_q};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (rd_en) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (first_q) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          state_d = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (iter_q == ITER_W'(1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = last_q ? ST_DIVS : ST_IDLE;
      ST_DIVS: begin
        if (iter_q == ITER_W'(1)) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (iter_q == ITER_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, iteration counter and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iter_q       <= '0;
      out_valid_q  <= 1'b0;
      out_bin_q    <= '0;
      out_mean_q   <= '0;
      out_stddev_q <= '0;
    end else begin
      state_q <= state_d;

      unique case (state_q)
        ST_READ: iter_q <= ITER_W'(MEAN_DIV_STEPS);
        ST_ACC:  iter_q <= ITER_W'(SUMSQ_DIV_STEPS);
        ST_DIVS: iter_q <= (iter_q == ITER_W'(1)) ? ITER_W'(SQRT_STEPS) : iter_q - ITER_W'(1);
        ST_DIVM, ST_SQRT: iter_q <= iter_q - ITER_W'(1);
        default: iter_q <= iter_q;
      endcase

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q  <= 1'b1;
        out_bin_q    <= bin_q;
        out_mean_q   <= mean_q;
        out_stddev_q <= root_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bin_q    <= bin_i;
      addr_q   <= ADDR_W'(bin_i);
      sample_q <= sample_i;
      first_q  <= first_i;
      last_q   <= last_i;
    end

    case (state_q)
      ST_READ: begin
        if (first_q) begin
          mean_q <= sample_q;
          root_q <= '0;
        end else begin
          mean_q    <= rd_q.mean;
          sumsq_q   <= rd_q.sumsq;
          cnt_q     <= n_new;
          div_rem_q <= '0;
          neg_q     <= (sample_q < rd_q.mean);
          if (sample_q < rd_q.mean) begin
            dmag_q <= rd_q.mean - sample_q;
            div_q  <= {rd_q.mean - sample_q, {(SUMSQ_W-DATA_W){1'b0}}};
          end else begin
            dmag_q <= sample_q - rd_q.mean;
            div_q  <= {sample_q - rd_q.mean, {(SUMSQ_W-DATA_W){1'b0}}};
          end
        end
      end
      ST_DIVM, ST_DIVS: begin
        div_q     <= {div_q[SUMSQ_W-2:0], div_ge};
        div_rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        if (state_q == ST_DIVS && iter_q == ITER_W'(1)) begin
          root_q   <= '0;
          sq_rem_q <= '0;
        end
      end
      ST_MUL: begin
        mean_q <= mean_new;
        prod_q <= SUMSQ_W'(dmag_q) * SUMSQ_W'(dev_new);
      end
      ST_ACC: begin
        div_q     <= sum_sat;
        div_rem_q <= '0;
      end
      ST_SQRT: begin
        div_q    <= {div_q[SUMSQ_W-3:0], 2'b00};
        root_q   <= {root_q[ROOT_W-2:0], sq_ge};
        sq_rem_q <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_shift[SQREM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Statistics memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stat_mem[addr_q] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= stat_mem[ADDR_W'(bin_i)];
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit step");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wr_entry.count != '0))
    else $error("zero count written back");

  a_sqrt_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> ({1'b0, sq_rem_q} <= {1'b0, root_q, 1'b0}))
    else $error("square root remainder out of bound");

  a_iter_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVM || state_q == ST_DIVS || state_q == ST_SQRT) |-> (iter_q != '0))
    else $error("iteration counter ran out");
`endif

endmodule
